// File: rtl/hfs_pkg.sv
// Shared types and constants for the height-map floor sampler.
`timescale 1ns / 1ps
package hfs_pkg;

   localparam int FRAC_BITS = 10;
   localparam int FRAC_ONE  = 1024;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Slope width (Q8.18, magnitude below 2^26), square-root and divider widths.
   localparam int DH_W       = 27;
   localparam int SQ_W       = 52;
   localparam int RAD_W      = 54;
   localparam int LEN_W      = 27;
   localparam int Q_W        = 15;
   localparam int NUM_W      = LEN_W + Q_W;
   localparam int SQRT_STEPS = RAD_W / 2;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_READ    = 8'b0000_0010,
      ST_BLEND   = 8'b0000_0100,
      ST_SQUARE  = 8'b0000_1000,
      ST_SUMSQ   = 8'b0001_0000,
      ST_ROOT    = 8'b0010_0000,
      ST_DIVGO   = 8'b0100_0000,
      ST_DIVWAIT = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      COMP_X = 2'd0,
      COMP_Y = 2'd1,
      COMP_Z = 2'd2
   } comp_type;

endpackage

// File: rtl/hfs_mem.sv
// Corner height memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module hfs_mem import hfs_pkg::*; #(
   parameter int AW = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [2**AW];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hfs_isqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module hfs_isqrt import hfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAD_W-1:0] radicand,
   output logic             done,
   output logic [LEN_W-1:0] root
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [RAD_W-1:0] n_ff, n_in;
   logic [RAD_W:0]   res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [RAD_W:0]   trial;
   logic             ge;

   assign trial = res_ff + {1'b0, bit_ff};
   assign ge    = {1'b0, n_ff} >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(SQRT_STEPS - 1);
         n_in    = radicand;
         res_in  = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 2);
      end else if (busy_ff) begin
         if (ge) begin
            n_in   = n_ff - trial[RAD_W-1:0];
            res_in = (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[LEN_W-1:0];

endmodule

// File: rtl/hfs_div.sv
// Restoring divider that produces a short quotient, one bit per cycle.
`timescale 1ns / 1ps
module hfs_div import hfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [LEN_W-1:0] denom,
   output logic             done,
   output logic [Q_W-1:0]   quo
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] den_ff, den_in;
   logic [Q_W-1:0]   low_ff, low_in;
   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, low_ff[Q_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      if (start) begin
         // The quotient is known to fit in Q_W bits, so the upper part of the
         // numerator is already below the divisor.
         busy_in = 1'b1;
         cnt_in  = 4'(Q_W - 1);
         rem_in  = numer[NUM_W-1:Q_W];
         low_in  = numer[Q_W-1:0];
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         low_in = {low_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
   end

   assign done = done_ff;
   assign quo  = low_ff;

endmodule

// File: rtl/heightmap_floor_sampler.sv
// Top level of the height-map floor sampler.
`timescale 1ns / 1ps
// The block keeps four signed Q8.8 corner heights per grid cell in one
// synchronous memory, addressed by cell index (z times grid width plus x)
// and corner. A word is taken on a clock edge where start is high and busy
// is low. An operation of zero writes one corner height; an operation of one
// samples the floor at the Q6.10 position pos_x, pos_z.
// Every word gives exactly one result word, shown on the rsp_ ports for one
// cycle while rsp_strobe is high. The receiver cannot stall, so nothing is
// ever held back. A write, and a sample whose cell lies outside the grid,
// answer on the cycle after the word is taken, and busy stays low, so such
// words can be given on every cycle.
// An in-range sample raises busy, and its result word shows in the same
// cycle as busy falls. The READ state reads the four corners through the
// single memory read port, the BLEND, SQUARE and SUMSQ states form the
// height, the slopes and the squared length, the 27-step square root runs,
// and each of the three normal components takes one 15-step divider run.
// The grid width must be written through csr_wr_en and csr_wr_data only
// while the block is idle; the block itself does not enforce this. Reset
// sets the grid width to 64 and returns to idle; the height memory is not
// cleared, and a corner must be written before it is sampled.
module heightmap_floor_sampler import hfs_pkg::*; #(
   parameter int GRID_SIDE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_z,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_z,
   input  logic [1:0]  req_corner,
   input  logic signed [15:0] req_height,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   output logic        rsp_strobe,
   output logic signed [15:0] rsp_floor_height,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic        rsp_out_of_range,
   output logic        rsp_write_done
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int CW    = $clog2(CELLS);
   localparam int AW    = CW + 2;

   state_type state_ff, state_in;

   logic [6:0]  gw_ff;
   logic [2:0]  rd_cnt_ff;
   logic [1:0]  comp_ff;
   logic [CW-1:0] cell_ff;
   logic [9:0]  u_ff, v_ff;
   logic signed [15:0] h_ff [4];
   logic signed [15:0] y_ff;
   logic signed [DH_W-1:0] dhu_ff, dhv_ff;
   logic [SQ_W-1:0] squ_ff, sqv_ff;
   logic [LEN_W-1:0] len_ff;
   logic signed [15:0] nx_ff, ny_ff;

   logic        rsp_strobe_ff;
   logic signed [15:0] rsp_height_ff, rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic        rsp_oor_ff, rsp_wdone_ff;

   // Cell lookup for the incoming word.
   logic [5:0]  lk_x, lk_z;
   logic [20:0] lin;
   logic        in_grid;
   logic        accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign lk_x   = (req_operation == OP_WRITE) ? req_cell_x : req_pos_x[15:10];
   assign lk_z   = (req_operation == OP_WRITE) ? req_cell_z : req_pos_z[15:10];
   assign lin    = 21'(lk_z) * 21'(gw_ff) + 21'(lk_x);
   assign in_grid = ({1'b0, lk_x} < gw_ff) && (lin < 21'(CELLS));

   // Height memory.
   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [15:0]   mem_rd_data;

   assign mem_wr_en   = accept && (req_operation == OP_WRITE) && in_grid;
   assign mem_wr_addr = {lin[CW-1:0], req_corner};
   assign mem_rd_en   = (state_ff == ST_READ) && !rd_cnt_ff[2];
   assign mem_rd_addr = {cell_ff, rd_cnt_ff[1:0]};

   hfs_mem #(.AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_height),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Triangle blend and bilinear slopes.
   logic        upper;
   logic signed [15:0] base;
   logic [10:0] w1, w2;
   logic signed [16:0] d1, d2;
   logic signed [29:0] y_full;
   logic signed [19:0] y_rnd;
   logic signed [15:0] y_sat;
   logic signed [29:0] dhu_full, dhv_full;
   logic signed [2*DH_W-1:0] squ_full, sqv_full;

   assign upper = (11'(u_ff) + 11'(v_ff)) > 11'(FRAC_ONE);

   always_comb begin
      if (upper) begin
         base = h_ff[3];
         w1   = 11'(FRAC_ONE) - 11'(u_ff);
         w2   = 11'(FRAC_ONE) - 11'(v_ff);
         d1   = 17'(h_ff[2]) - 17'(h_ff[3]);
         d2   = 17'(h_ff[1]) - 17'(h_ff[3]);
      end else begin
         base = h_ff[0];
         w1   = 11'(u_ff);
         w2   = 11'(v_ff);
         d1   = 17'(h_ff[1]) - 17'(h_ff[0]);
         d2   = 17'(h_ff[2]) - 17'(h_ff[0]);
      end
   end

   assign y_full = (30'(base) <<< FRAC_BITS)
                 + 30'($signed({1'b0, w1})) * 30'(d1)
                 + 30'($signed({1'b0, w2})) * 30'(d2);
   // Round half up to Q8.8, then saturate.
   assign y_rnd  = 20'((y_full + 30'sd512) >>> FRAC_BITS);
   assign y_sat  = (y_rnd > 20'sd32767)  ? 16'sh7FFF :
                   (y_rnd < -20'sd32768) ? 16'sh8000 : y_rnd[15:0];

   assign dhu_full =
      30'($signed({1'b0, 11'(FRAC_ONE) - 11'(v_ff)})) * 30'(17'(h_ff[1]) - 17'(h_ff[0]))
    + 30'($signed({1'b0, 11'(v_ff)})) * 30'(17'(h_ff[3]) - 17'(h_ff[2]));
   assign dhv_full =
      30'($signed({1'b0, 11'(FRAC_ONE) - 11'(u_ff)})) * 30'(17'(h_ff[2]) - 17'(h_ff[0]))
    + 30'($signed({1'b0, 11'(u_ff)})) * 30'(17'(h_ff[3]) - 17'(h_ff[1]));

   assign squ_full = dhu_ff * dhu_ff;
   assign sqv_full = dhv_ff * dhv_ff;

   // Square root of the squared normal length. The radicand is summed from
   // the registered squares in the cycle that starts the root.
   logic [RAD_W-1:0] rad;
   logic             sqrt_done;
   logic [LEN_W-1:0] sqrt_root;

   assign rad = RAD_W'(squ_ff) + RAD_W'(sqv_ff) + (RAD_W'(1) << 36);

   hfs_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_SUMSQ),
      .radicand (rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Normal components, one division each.
   logic [DH_W-1:0]  mag;
   logic             neg;
   logic [NUM_W-1:0] numer;
   logic             div_done;
   logic [Q_W-1:0]   div_quo;
   logic signed [15:0] comp_val;

   always_comb begin
      case (comp_ff)
         COMP_X: begin
            mag = dhu_ff[DH_W-1] ? DH_W'(-dhu_ff) : DH_W'(dhu_ff);
            neg = !dhu_ff[DH_W-1] && (dhu_ff != '0);
         end
         COMP_Y: begin
            mag = DH_W'(1) << 18;
            neg = 1'b0;
         end
         COMP_Z: begin
            mag = dhv_ff[DH_W-1] ? DH_W'(-dhv_ff) : DH_W'(dhv_ff);
            neg = !dhv_ff[DH_W-1] && (dhv_ff != '0);
         end
         default: begin
            mag = '0;
            neg = 1'b0;
         end
      endcase
   end

   assign numer    = (NUM_W'(mag) << 14) + NUM_W'(len_ff >> 1);
   assign comp_val = neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

   hfs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DIVGO),
      .numer (numer),
      .denom (len_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_SAMPLE) && in_grid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (rd_cnt_ff == 3'd4) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUMSQ;
         ST_SUMSQ:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = ST_DIVGO;
            end
         end
         ST_DIVGO:  state_in = ST_DIVWAIT;
         ST_DIVWAIT: begin
            if (div_done) begin
               state_in = (comp_ff == COMP_Z) ? ST_IDLE : ST_DIVGO;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gw_ff         <= 7'd64;
         rsp_strobe_ff <= 1'b0;
         rd_cnt_ff     <= '0;
         comp_ff       <= COMP_X;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            gw_ff <= csr_wr_data;
         end
         if (accept) begin
            rd_cnt_ff <= '0;
            comp_ff   <= COMP_X;
            if ((req_operation == OP_WRITE) || !in_grid) begin
               rsp_strobe_ff <= 1'b1;
            end
         end
         if (state_ff == ST_READ) begin
            rd_cnt_ff <= rd_cnt_ff + 3'd1;
         end
         if ((state_ff == ST_DIVWAIT) && div_done) begin
            comp_ff <= comp_ff + 2'd1;
            if (comp_ff == COMP_Z) begin
               rsp_strobe_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cell_ff       <= lin[CW-1:0];
         u_ff          <= req_pos_x[9:0];
         v_ff          <= req_pos_z[9:0];
         rsp_height_ff <= '0;
         rsp_nx_ff     <= '0;
         rsp_ny_ff     <= '0;
         rsp_nz_ff     <= '0;
         rsp_oor_ff    <= !in_grid;
         rsp_wdone_ff  <= (req_operation == OP_WRITE);
      end
      if ((state_ff == ST_READ) && (rd_cnt_ff != 3'd0)) begin
         h_ff[2'(rd_cnt_ff - 3'd1)] <= mem_rd_data;
      end
      if (state_ff == ST_BLEND) begin
         y_ff   <= y_sat;
         dhu_ff <= DH_W'(dhu_full);
         dhv_ff <= DH_W'(dhv_full);
      end
      if (state_ff == ST_SQUARE) begin
         squ_ff <= squ_full[SQ_W-1:0];
         sqv_ff <= sqv_full[SQ_W-1:0];
      end
      if (sqrt_done) begin
         len_ff <= sqrt_root;
      end
      if ((state_ff == ST_DIVWAIT) && div_done) begin
         case (comp_ff)
            COMP_X: nx_ff <= comp_val;
            COMP_Y: ny_ff <= comp_val;
            COMP_Z: begin
               rsp_height_ff <= y_ff;
               rsp_nx_ff     <= nx_ff;
               rsp_ny_ff     <= ny_ff;
               rsp_nz_ff     <= comp_val;
            end
            default: ;
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_floor_height = rsp_height_ff;
   assign rsp_normal_x     = rsp_nx_ff;
   assign rsp_normal_y     = rsp_ny_ff;
   assign rsp_normal_z     = rsp_nz_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_write_done   = rsp_wdone_ff;

endmodule

// File: test/heightmap_floor_sampler_test.sv
// Self-checking testbench for the height-map floor sampler top level.
`timescale 1ns / 1ps
// The test drives corner writes and floor samples through the start/busy
// handshake with random gaps between words, and keeps its own model of the
// height memory and the grid width. Each accepted word is turned into one
// expected result word at the moment it is taken; a checker process compares
// every strobed result word field by field with the oldest expected word.
// A sample of an in-range cell is only issued once all four corners of that
// cell have been written, since the memory is not cleared by reset.
module heightmap_floor_sampler_test import hfs_pkg::*; ();

   localparam int SIDE    = 64;
   localparam int ENTRIES = SIDE * SIDE * 4;

   typedef struct {
      logic signed [15:0] floor_height;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               out_of_range;
      logic               write_done;
   } floor_word_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [15:0] req_pos_x;
   logic [15:0] req_pos_z;
   logic [5:0]  req_cell_x;
   logic [5:0]  req_cell_z;
   logic [1:0]  req_corner;
   logic signed [15:0] req_height;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;
   logic        rsp_strobe;
   logic signed [15:0] rsp_floor_height;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic        rsp_out_of_range;
   logic        rsp_write_done;

   // Model state: the height memory, which entries hold a written value,
   // and the grid width currently programmed.
   logic [15:0] model_heights [ENTRIES];
   bit          model_written [ENTRIES];
   int          model_width;

   floor_word_type expected_words[$];
   bit          failed;

   heightmap_floor_sampler #(.GRID_SIDE(SIDE)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_pos_x(req_pos_x), .req_pos_z(req_pos_z),
      .req_cell_x(req_cell_x), .req_cell_z(req_cell_z), .req_corner(req_corner),
      .req_height(req_height), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_strobe(rsp_strobe), .rsp_floor_height(rsp_floor_height),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_out_of_range(rsp_out_of_range),
      .rsp_write_done(rsp_write_done)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A fixed ceiling on the run time.
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Returns the linear cell index, or -1 when the cell is outside the grid.
   function automatic int cell_of(int x, int z);
      if (x >= model_width) return -1;
      if (z * model_width + x >= SIDE * SIDE) return -1;
      return z * model_width + x;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe >>= 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n    -= root + probe;
            root  = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // Scales one normal component to Q1.14, rounding half away from zero.
   function automatic logic signed [15:0] unit_component(longint c, longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = longint'(c < 0 ? -c : c) << 14;
      q   = (mag + len / 2) / len;
      return c < 0 ? 16'(-longint'(q)) : 16'(q);
   endfunction

   // Works out the result of one accepted word and applies its side effect.
   function automatic floor_word_type predict_floor_word(logic op, logic [15:0] px,
         logic [15:0] pz, logic [5:0] cx, logic [5:0] cz, logic [1:0] cr,
         logic [15:0] h);
      floor_word_type w;
      int cell_idx;
      longint u, v, h00, h10, h01, h11, y, dhu, dhv;
      longint unsigned len;
      w = '{default: '0};
      if (op == OP_WRITE) begin
         cell_idx = cell_of(cx, cz);
         if (cell_idx >= 0) begin
            model_heights[cell_idx * 4 + cr] = h;
            model_written[cell_idx * 4 + cr] = 1'b1;
         end else begin
            w.out_of_range = 1'b1;
         end
         w.write_done = 1'b1;
         return w;
      end
      cell_idx = cell_of(px >> FRAC_BITS, pz >> FRAC_BITS);
      if (cell_idx < 0) begin
         w.out_of_range = 1'b1;
         return w;
      end
      u   = px & (FRAC_ONE - 1);
      v   = pz & (FRAC_ONE - 1);
      h00 = longint'($signed(model_heights[cell_idx * 4 + 0]));
      h10 = longint'($signed(model_heights[cell_idx * 4 + 1]));
      h01 = longint'($signed(model_heights[cell_idx * 4 + 2]));
      h11 = longint'($signed(model_heights[cell_idx * 4 + 3]));
      // Lower triangle when u + v stays at or below one, upper otherwise.
      if (u + v <= FRAC_ONE)
         y = h00 * FRAC_ONE + u * (h10 - h00) + v * (h01 - h00);
      else
         y = h11 * FRAC_ONE + (FRAC_ONE - u) * (h01 - h11) + (FRAC_ONE - v) * (h10 - h11);
      y = (y + 512) >>> FRAC_BITS;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      dhu = (FRAC_ONE - v) * (h10 - h00) + v * (h11 - h01);
      dhv = (FRAC_ONE - u) * (h01 - h00) + u * (h11 - h10);
      len = floor_sqrt(longint'(dhu * dhu) + longint'(dhv * dhv) + (64'd1 << 36));
      w.floor_height = 16'(y);
      w.normal_x     = unit_component(-dhu, len);
      w.normal_y     = unit_component(64'sd1 << 18, len);
      w.normal_z     = unit_component(-dhv, len);
      return w;
   endfunction

   // Sends one word after a random gap and records its expected result once
   // the block takes it. Start is only lowered when a gap follows.
   task automatic send_word(logic op, logic [15:0] px, logic [15:0] pz,
         logic [5:0] cx, logic [5:0] cz, logic [1:0] cr, logic [15:0] h);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_pos_x     <= px;
      req_pos_z     <= pz;
      req_cell_x    <= cx;
      req_cell_z    <= cz;
      req_corner    <= cr;
      req_height    <= h;
      do @(posedge clock); while (busy);
      expected_words.push_back(predict_floor_word(op, px, pz, cx, cz, cr, h));
   endtask

   task automatic write_corner(int cx, int cz, int cr, logic [15:0] h);
      send_word(OP_WRITE, 16'($urandom), 16'($urandom), 6'(cx), 6'(cz), 2'(cr), h);
   endtask

   task automatic sample_at(logic [15:0] px, logic [15:0] pz);
      send_word(OP_SAMPLE, px, pz, 6'($urandom), 6'($urandom), 2'($urandom),
                16'($urandom));
   endtask

   function automatic logic [15:0] random_height();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         1: return 16'($signed($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Writes any corner of the cell that holds no value yet.
   task automatic fill_cell(int cell_x, int cell_z);
      int cell_idx;
      cell_idx = cell_of(cell_x, cell_z);
      if (cell_idx < 0) return;
      for (int k = 0; k < 4; k++)
         if (!model_written[cell_idx * 4 + k]) write_corner(cell_x, cell_z, k, random_height());
   endtask

   // Grid width is changed only with the block idle and every result in.
   task automatic set_grid_width(int width);
      start <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 7'(width);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_width  = width;
   endtask

   // Every strobed result word is checked against the oldest expected word.
   always @(posedge clock) begin
      floor_word_type e;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            failed = 1'b1;
         end else begin
            e = expected_words.pop_front();
            if (rsp_floor_height !== e.floor_height) begin
               $error("floor_height expected %0d actual %0d", e.floor_height, rsp_floor_height);
               failed = 1'b1;
            end
            if (rsp_normal_x !== e.normal_x) begin
               $error("normal_x expected %0d actual %0d", e.normal_x, rsp_normal_x);
               failed = 1'b1;
            end
            if (rsp_normal_y !== e.normal_y) begin
               $error("normal_y expected %0d actual %0d", e.normal_y, rsp_normal_y);
               failed = 1'b1;
            end
            if (rsp_normal_z !== e.normal_z) begin
               $error("normal_z expected %0d actual %0d", e.normal_z, rsp_normal_z);
               failed = 1'b1;
            end
            if (rsp_out_of_range !== e.out_of_range) begin
               $error("out_of_range expected %0b actual %0b", e.out_of_range,
                      rsp_out_of_range);
               failed = 1'b1;
            end
            if (rsp_write_done !== e.write_done) begin
               $error("write_done expected %0b actual %0b", e.write_done, rsp_write_done);
               failed = 1'b1;
            end
         end
      end
   end

   // Steep extreme corners, both triangles, the diagonal itself and the far
   // corner of the grid.
   task automatic test_extreme_cells();
      write_corner(0, 0, 0, 16'h8000);
      write_corner(0, 0, 1, 16'h7FFF);
      write_corner(0, 0, 2, 16'h7FFF);
      write_corner(0, 0, 3, 16'h8000);
      sample_at(16'h0000, 16'h0000);
      sample_at(16'h03FF, 16'h03FF);
      sample_at(16'h0200, 16'h0200);  // exactly on the diagonal
      sample_at(16'h0201, 16'h0200);  // just into the upper triangle
      sample_at(16'h03FF, 16'h0000);
      sample_at(16'h0000, 16'h03FF);
      write_corner(63, 63, 0, 16'h7FFF);
      write_corner(63, 63, 1, 16'h7FFF);
      write_corner(63, 63, 2, 16'h7FFF);
      write_corner(63, 63, 3, 16'h7FFF);
      sample_at(16'hFFFF, 16'hFFFF);
      sample_at(16'hFC00, 16'hFC00);
   endtask

   // Cells past the row width or past the end of the memory.
   task automatic test_out_of_range();
      set_grid_width(1);
      sample_at(16'h0400, 16'h0000);
      write_corner(1, 0, 2, 16'h1234);
      write_corner(0, 63, 3, 16'h4321);
      fill_cell(0, 5);
      sample_at(16'h0155, 16'h16AA);
      set_grid_width(64);
      set_grid_width(65);
      write_corner(0, 63, 0, 16'h0101);  // 63 * 65 lands on the last cell
      sample_at(16'h0000, 16'hFC00);
      sample_at(16'hFFFF, 16'hFFFF);     // runs past the memory
      set_grid_width(64);
   endtask

   task automatic test_random_traffic(int count);
      int cx, cz, zmax;
      logic [15:0] px, pz;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1: write_corner($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 3), random_height());
            2: begin
               px = 16'($urandom);
               pz = 16'($urandom);
               fill_cell(px >> FRAC_BITS, pz >> FRAC_BITS);
               sample_at(px, pz);
            end
            default: begin
               cx   = $urandom_range(0, model_width - 1);
               zmax = (SIDE * SIDE - 1 - cx) / model_width;
               if (zmax > 63) zmax = 63;
               cz   = $urandom_range(0, zmax);
               fill_cell(cx, cz);
               sample_at({6'(cx), 10'($urandom)}, {6'(cz), 10'($urandom)});
            end
         endcase
      end
   endtask

   initial begin
      failed        = 1'b0;
      model_width   = 64;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= OP_WRITE;
      req_pos_x     <= '0;
      req_pos_z     <= '0;
      req_cell_x    <= '0;
      req_cell_z    <= '0;
      req_corner    <= '0;
      req_height    <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_cells();
      test_out_of_range();
      test_random_traffic(100);
      set_grid_width(1);
      test_random_traffic(100);
      set_grid_width($urandom_range(2, 63));
      test_random_traffic(80);
      set_grid_width(64);
      test_random_traffic(100);

      start <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/hfs_pkg.sv
rtl/hfs_mem.sv
rtl/hfs_isqrt.sv
rtl/hfs_div.sv
rtl/heightmap_floor_sampler.sv
test/heightmap_floor_sampler_test.sv
